// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition that holds at every clock edge outside reset.
`define DFSM_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed");
// Consequence that holds at the clock edge after the antecedent.
`define DFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DFSM_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define DFSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/dfsm_pkg.sv =====
// Types, codes and constants of the debounced fault safety monitor.
`default_nettype none
package dfsm_pkg;

	typedef enum logic [2:0] {
		REQ_ENCODER = 3'd0,
		REQ_CURRENT = 3'd1,
		REQ_SUPPLY  = 3'd2,
		REQ_TICK    = 3'd3,
		REQ_CLEAR   = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		REG_ENC_TIMEOUT  = 2'd0,
		REG_OC_LIMIT     = 2'd1,
		REG_SUPPLY_LOW   = 2'd2,
		REG_RECOV_DELAY  = 2'd3
	} reg_index_t;

	localparam logic [7:0] F_STALE   = 8'h01;
	localparam logic [7:0] F_INVALID = 8'h02;
	localparam logic [7:0] F_OC_L    = 8'h04;
	localparam logic [7:0] F_OC_R    = 8'h08;
	localparam logic [7:0] F_POWER   = 8'h10;

	localparam logic [7:0] DEB_ENC_LIMIT = 8'd2;
	localparam logic [7:0] DEB_OC_LIMIT  = 8'd3;
	localparam logic [7:0] DEB_PWR_LIMIT = 8'd4;

	localparam int unsigned DEB_ENC = 0;
	localparam int unsigned DEB_OCL = 1;
	localparam int unsigned DEB_OCR = 2;
	localparam int unsigned DEB_PWR = 3;

	localparam int unsigned CNT_SAFE  = 0;
	localparam int unsigned CNT_ENC   = 1;
	localparam int unsigned CNT_OC    = 2;
	localparam int unsigned CNT_PWR   = 3;
	localparam int unsigned CNT_RECOV = 4;
	localparam int unsigned CNT_KICK  = 5;

	localparam logic [31:0] RST_ENC_TIMEOUT = 32'd500;
	localparam logic [15:0] RST_OC_LIMIT    = 16'd3000;
	localparam logic [15:0] RST_SUPPLY_LOW  = 16'd10000;
	localparam logic [31:0] RST_RECOV_DELAY = 32'd1000;

	typedef struct packed {
		logic [31:0] enc_timeout;
		logic [15:0] oc_limit;
		logic [15:0] supply_low;
		logic [31:0] recov_delay;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] now_ms;
		logic        encoder_valid;
		logic [15:0] current_left;
		logic [15:0] current_right;
		logic [15:0] supply_reading;
	} item_t;

	typedef struct packed {
		logic [7:0]       fault_bits;
		logic [7:0]       latched_bits;
		logic             safe;
		logic [31:0]      entry_time;
		logic [31:0]      last_enc;
		logic [3:0][7:0]  deb;
		logic [5:0][31:0] counts;
	} state_t;

	typedef struct packed {
		state_t st;
		logic   kick;
		logic   rec;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/dfsm_cfg_regs.sv =====
// APB-style configuration registers of the monitor.
`default_nettype none
module dfsm_cfg_regs
	import dfsm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t       cfg_q;
	reg_index_t idx;

	assign idx    = reg_index_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enc_timeout <= RST_ENC_TIMEOUT;
			cfg_q.oc_limit    <= RST_OC_LIMIT;
			cfg_q.supply_low  <= RST_SUPPLY_LOW;
			cfg_q.recov_delay <= RST_RECOV_DELAY;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_ENC_TIMEOUT: cfg_q.enc_timeout <= pwdata;
				REG_OC_LIMIT:    cfg_q.oc_limit    <= pwdata[15:0];
				REG_SUPPLY_LOW:  cfg_q.supply_low  <= pwdata[15:0];
				REG_RECOV_DELAY: cfg_q.recov_delay <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENC_TIMEOUT: prdata = cfg_q.enc_timeout;
			REG_OC_LIMIT:    prdata = {16'd0, cfg_q.oc_limit};
			REG_SUPPLY_LOW:  prdata = {16'd0, cfg_q.supply_low};
			REG_RECOV_DELAY: prdata = cfg_q.recov_delay;
			default:         prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/dfsm_update.sv =====
// Next-state and result logic for one monitoring transaction.
`default_nettype none
module dfsm_update
	import dfsm_pkg::*;
(
	input  wire item_t  item,
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	output result_t res
);

	logic [31:0] enc_age;
	logic [31:0] safe_age;
	logic        enter;
	logic        ocl_conf;
	logic        ocr_conf;
	state_t      nxt;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	assign enc_age  = item.now_ms - cur.last_enc;
	assign safe_age = item.now_ms - cur.entry_time;

	always_comb begin
		nxt      = cur;
		enter    = 1'b0;
		ocl_conf = 1'b0;
		ocr_conf = 1'b0;
		res.kick = 1'b0;
		res.rec  = 1'b0;
		case (req_code_t'(item.req_type))
			REQ_ENCODER: begin
				if (item.encoder_valid) begin
					nxt.last_enc     = item.now_ms;
					nxt.deb[DEB_ENC] = 8'd0;
					nxt.fault_bits   = cur.fault_bits & ~(F_STALE | F_INVALID);
				end else if (enc_age > cfg.enc_timeout) begin
					nxt.deb[DEB_ENC] = sat_inc(cur.deb[DEB_ENC]);
					if (nxt.deb[DEB_ENC] >= DEB_ENC_LIMIT) begin
						nxt.fault_bits       = cur.fault_bits | F_STALE | F_INVALID;
						nxt.latched_bits     = cur.latched_bits | F_INVALID;
						nxt.counts[CNT_ENC]  = cur.counts[CNT_ENC] + 32'd1;
						enter                = 1'b1;
					end
				end
			end
			REQ_CURRENT: begin
				if (item.current_left > cfg.oc_limit) begin
					nxt.deb[DEB_OCL] = sat_inc(cur.deb[DEB_OCL]);
					ocl_conf         = nxt.deb[DEB_OCL] >= DEB_OC_LIMIT;
				end else begin
					nxt.deb[DEB_OCL] = 8'd0;
				end
				if (item.current_right > cfg.oc_limit) begin
					nxt.deb[DEB_OCR] = sat_inc(cur.deb[DEB_OCR]);
					ocr_conf         = nxt.deb[DEB_OCR] >= DEB_OC_LIMIT;
				end else begin
					nxt.deb[DEB_OCR] = 8'd0;
				end
				// A reading at or below the limit clears that motor's active bit.
				nxt.fault_bits = cur.fault_bits
					& ~((item.current_left  > cfg.oc_limit) ? 8'd0 : F_OC_L)
					& ~((item.current_right > cfg.oc_limit) ? 8'd0 : F_OC_R);
				nxt.fault_bits   = nxt.fault_bits | (ocl_conf ? F_OC_L : 8'd0)
					| (ocr_conf ? F_OC_R : 8'd0);
				nxt.latched_bits = cur.latched_bits | (ocl_conf ? F_OC_L : 8'd0)
					| (ocr_conf ? F_OC_R : 8'd0);
				nxt.counts[CNT_OC] = cur.counts[CNT_OC] + {31'd0, ocl_conf}
					+ {31'd0, ocr_conf};
				enter = ocl_conf | ocr_conf;
			end
			REQ_SUPPLY: begin
				if (item.supply_reading < cfg.supply_low) begin
					nxt.deb[DEB_PWR] = sat_inc(cur.deb[DEB_PWR]);
					if (nxt.deb[DEB_PWR] >= DEB_PWR_LIMIT) begin
						nxt.fault_bits      = cur.fault_bits | F_POWER;
						nxt.latched_bits    = cur.latched_bits | F_POWER;
						nxt.counts[CNT_PWR] = cur.counts[CNT_PWR] + 32'd1;
						enter               = 1'b1;
					end
				end else begin
					nxt.deb[DEB_PWR] = 8'd0;
					nxt.fault_bits   = cur.fault_bits & ~F_POWER;
				end
			end
			REQ_TICK: begin
				if (!cur.safe) begin
					res.kick             = 1'b1;
					nxt.counts[CNT_KICK] = cur.counts[CNT_KICK] + 32'd1;
				end else if (cur.fault_bits == 8'd0 && safe_age > cfg.recov_delay) begin
					nxt.safe              = 1'b0;
					nxt.counts[CNT_RECOV] = cur.counts[CNT_RECOV] + 32'd1;
					nxt.last_enc          = item.now_ms;
					res.rec               = 1'b1;
				end
			end
			REQ_CLEAR: begin
				nxt.fault_bits   = 8'd0;
				nxt.latched_bits = 8'd0;
				nxt.deb          = '0;
				nxt.safe         = 1'b0;
			end
			default: ;
		endcase
		// Entry into the safe state happens once; a later confirmation leaves the time.
		if (enter && !cur.safe) begin
			nxt.safe             = 1'b1;
			nxt.entry_time       = item.now_ms;
			nxt.counts[CNT_SAFE] = cur.counts[CNT_SAFE] + 32'd1;
		end
		res.st = nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/core/debounced_fault_safety_monitor_core.sv =====
// Top level of the debounced fault safety monitor.
`default_nettype none
`include "assert_macros.svh"
// The monitor takes one event transaction per clock cycle (encoder check, motor
// current check, supply check, tick or fault clear) and returns one result
// transaction for each, in order. A transaction accepted on the request side is
// held in an input register; the update logic reads it together with the fault
// state and the configuration, and the new state and the result are written at the
// same edge once the result register is free, so a new transaction can follow in
// every cycle while the result side does not stall. The sustained rate of one
// transaction per cycle is set by the state update loop. When the result register
// is full and stalled, the input register still fills, and the request side is
// stalled only while both hold a transaction. The user must write configuration
// through the APB port only while no transaction is in flight; the block does not
// enforce this. The registers lie at byte addresses 0, 4, 8 and 12 in the order
// encoder timeout, overcurrent limit, low-supply threshold and recovery delay.
module debounced_fault_safety_monitor_core
	import dfsm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] now_ms,
	input  wire logic        encoder_valid,
	input  wire logic [15:0] current_left,
	input  wire logic [15:0] current_right,
	input  wire logic [15:0] supply_reading,
	// result channel
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [7:0]  active_faults,
	output logic      [7:0]  latched_faults,
	output logic             safe_state,
	output logic             watchdog_kick,
	output logic             recovered,
	output logic      [31:0] safe_entries,
	output logic      [31:0] encoder_timeout_events,
	output logic      [31:0] overcurrent_count,
	output logic      [31:0] power_low_count,
	output logic      [31:0] recovery_count,
	output logic      [31:0] kick_count
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	state_t  state_q;
	result_t upd;
	logic    move_s1;
	logic    take_in;

	dfsm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The stage moves on when the result register is empty or being emptied.
	assign move_s1   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !move_s1;
	assign take_in   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.req_type       <= req_type;
			item_s1.now_ms         <= now_ms;
			item_s1.encoder_valid  <= encoder_valid;
			item_s1.current_left   <= current_left;
			item_s1.current_right  <= current_right;
			item_s1.supply_reading <= supply_reading;
		end
	end

	dfsm_update u_update (
		.item(item_s1),
		.cfg (cfg),
		.cur (state_q),
		.res (upd)
	);

	// Fault state advances exactly once for each transaction leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (move_s1) begin
				state_q <= upd.st;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_s2 <= upd;
		end
	end

	assign rsp_valid              = valid_s2;
	assign active_faults          = result_s2.st.fault_bits;
	assign latched_faults         = result_s2.st.latched_bits;
	assign safe_state             = result_s2.st.safe;
	assign watchdog_kick          = result_s2.kick;
	assign recovered              = result_s2.rec;
	assign safe_entries           = result_s2.st.counts[CNT_SAFE];
	assign encoder_timeout_events = result_s2.st.counts[CNT_ENC];
	assign overcurrent_count      = result_s2.st.counts[CNT_OC];
	assign power_low_count        = result_s2.st.counts[CNT_PWR];
	assign recovery_count         = result_s2.st.counts[CNT_RECOV];
	assign kick_count             = result_s2.st.counts[CNT_KICK];

	// A set overcurrent, power or invalid bit is always latched as well.
	`DFSM_ASSERT_ALWAYS(a_active_latched, clk, arst_n,
		(state_q.fault_bits & ~state_q.latched_bits & 8'h1E) == 8'd0)
	// The stale bit never stands without the invalid bit.
	`DFSM_ASSERT_ALWAYS(a_stale_invalid, clk, arst_n,
		!state_q.fault_bits[0] || state_q.fault_bits[1])
	// A recovery leaves the safe state and never kicks the watchdog in the same result.
	`DFSM_ASSERT_ALWAYS(a_recover_result, clk, arst_n,
		!(valid_s2 && recovered) || (!safe_state && !watchdog_kick))
	// The state holds while no transaction leaves the input stage.
	`DFSM_ASSERT_NEXT(a_state_hold, clk, arst_n, !move_s1, $stable(state_q))
	// A stalled result is not overwritten.
	`DFSM_ASSERT_NEXT(a_result_hold, clk, arst_n, valid_s2 && rsp_stall,
		valid_s2 && $stable(result_s2))

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the debounced fault safety monitor core.
`timescale 1ns / 1ps

module tb;
	import dfsm_pkg::*;

	// Request codes 5 to 7 are not decoded by the block; they must leave the state alone.
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	// Cycle limit for the run watchdog, ample for a correct run.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 180;

	// Idling modes, cycled through phase by phase: none, sender, receiver, both.
	localparam int unsigned SEND_IDLE_PCT [4] = '{0, 63, 0, 19};
	localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 63, 19};

	// What one result transaction reports: the fault bits, the flags and the counters.
	typedef struct packed {
		logic [7:0]       active;
		logic [7:0]       latched;
		logic             safe;
		logic             kick;
		logic             rec;
		logic [5:0][31:0] counts;
	} status_t;

	// One request transaction waiting to be sent. Where pinned is set, the status that
	// it must produce is typed in by hand rather than taken from the predictor.
	typedef struct {
		item_t   ev;
		bit      pinned;
		status_t want;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  req_type;
	logic [31:0] now_ms;
	logic        encoder_valid;
	logic [15:0] current_left;
	logic [15:0] current_right;
	logic [15:0] supply_reading;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [7:0]  active_faults;
	logic [7:0]  latched_faults;
	logic        safe_state;
	logic        watchdog_kick;
	logic        recovered;
	logic [31:0] safe_entries;
	logic [31:0] encoder_timeout_events;
	logic [31:0] overcurrent_count;
	logic [31:0] power_low_count;
	logic [31:0] recovery_count;
	logic [31:0] kick_count;

	debounced_fault_safety_monitor_core dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready),
		.req_valid              (req_valid),
		.req_stall              (req_stall),
		.req_type               (req_type),
		.now_ms                 (now_ms),
		.encoder_valid          (encoder_valid),
		.current_left           (current_left),
		.current_right          (current_right),
		.supply_reading         (supply_reading),
		.rsp_valid              (rsp_valid),
		.rsp_stall              (rsp_stall),
		.active_faults          (active_faults),
		.latched_faults         (latched_faults),
		.safe_state             (safe_state),
		.watchdog_kick          (watchdog_kick),
		.recovered              (recovered),
		.safe_entries           (safe_entries),
		.encoder_timeout_events (encoder_timeout_events),
		.overcurrent_count      (overcurrent_count),
		.power_low_count        (power_low_count),
		.recovery_count         (recovery_count),
		.kick_count             (kick_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The testbench's own copy of the monitor state and of its configuration.
	cfg_t             cfg_model;
	logic [7:0]       fault_bits;
	logic [7:0]       latched_bits;
	logic             safe_on;
	logic [31:0]      entry_ms;
	logic [31:0]      last_enc_ms;
	logic [3:0][7:0]  deb;
	logic [5:0][31:0] counts;

	stim_t       events_to_send[$];
	status_t     pending_status[$];
	int unsigned status_owed = 0;
	stim_t       held;
	status_t     predicted;
	status_t     want_st;
	status_t     seen_st;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	logic [31:0] clock_ms = 32'd0;
	string       count_names[6] = '{"safe_entries", "encoder_timeout_events",
		"overcurrent_count", "power_low_count", "recovery_count", "kick_count"};

	function automatic void bump(int unsigned slot);
		if (deb[slot] != 8'hFF)
			deb[slot] = deb[slot] + 8'd1;
	endfunction

	// A confirmation while already safe keeps the original entry time and count.
	function automatic void enter_safe(logic [31:0] now);
		if (!safe_on) begin
			safe_on = 1'b1;
			entry_ms = now;
			counts[CNT_SAFE] = counts[CNT_SAFE] + 32'd1;
		end
	endfunction

	function automatic void motor_check(logic [15:0] amps, int unsigned slot,
			logic [7:0] mask, logic [31:0] now);
		if (amps > cfg_model.oc_limit) begin
			bump(slot);
			// Every reading at or past the debounce count confirms again.
			if (deb[slot] >= DEB_OC_LIMIT) begin
				fault_bits |= mask;
				latched_bits |= mask;
				counts[CNT_OC] = counts[CNT_OC] + 32'd1;
				enter_safe(now);
			end
		end else begin
			deb[slot] = 8'd0;
			fault_bits &= ~mask;
		end
	endfunction

	// Applies one request to the state copy and returns the status that it yields.
	function automatic status_t advance_monitor(item_t ev);
		status_t     st;
		logic        kick;
		logic        rec;
		logic [31:0] since;
		kick = 1'b0;
		rec = 1'b0;
		case (ev.req_type)
		REQ_ENCODER: begin
			since = ev.now_ms - last_enc_ms;
			if (ev.encoder_valid) begin
				last_enc_ms = ev.now_ms;
				deb[DEB_ENC] = 8'd0;
				fault_bits &= ~(F_STALE | F_INVALID);
			end else if (since > cfg_model.enc_timeout) begin
				bump(DEB_ENC);
				// Only the invalid bit is latched, and the timeout always forces safe.
				if (deb[DEB_ENC] >= DEB_ENC_LIMIT) begin
					fault_bits |= F_STALE | F_INVALID;
					latched_bits |= F_INVALID;
					counts[CNT_ENC] = counts[CNT_ENC] + 32'd1;
					enter_safe(ev.now_ms);
				end
			end
		end
		REQ_CURRENT: begin
			motor_check(ev.current_left, DEB_OCL, F_OC_L, ev.now_ms);
			motor_check(ev.current_right, DEB_OCR, F_OC_R, ev.now_ms);
		end
		REQ_SUPPLY: begin
			if (ev.supply_reading < cfg_model.supply_low) begin
				bump(DEB_PWR);
				if (deb[DEB_PWR] >= DEB_PWR_LIMIT) begin
					fault_bits |= F_POWER;
					latched_bits |= F_POWER;
					counts[CNT_PWR] = counts[CNT_PWR] + 32'd1;
					enter_safe(ev.now_ms);
				end
			end else begin
				deb[DEB_PWR] = 8'd0;
				fault_bits &= ~F_POWER;
			end
		end
		REQ_TICK: begin
			since = ev.now_ms - entry_ms;
			if (!safe_on) begin
				kick = 1'b1;
				counts[CNT_KICK] = counts[CNT_KICK] + 32'd1;
			end else if (fault_bits == 8'd0 && since > cfg_model.recov_delay) begin
				// Leaving the safe state also restarts the encoder staleness timer.
				safe_on = 1'b0;
				counts[CNT_RECOV] = counts[CNT_RECOV] + 32'd1;
				last_enc_ms = ev.now_ms;
				rec = 1'b1;
			end
		end
		REQ_CLEAR: begin
			// The event counters survive a clear; everything else fault-related goes.
			fault_bits = 8'd0;
			latched_bits = 8'd0;
			deb = '0;
			safe_on = 1'b0;
		end
		default: ;
		endcase
		st.active = fault_bits;
		st.latched = latched_bits;
		st.safe = safe_on;
		st.kick = kick;
		st.rec = rec;
		st.counts = counts;
		return st;
	endfunction

	function automatic status_t make_status(logic [7:0] act, logic [7:0] lat, logic safe,
			logic kick, logic rec, logic [31:0] n_safe, logic [31:0] n_enc,
			logic [31:0] n_oc, logic [31:0] n_pwr, logic [31:0] n_rec, logic [31:0] n_kick);
		status_t st;
		st.active = act;
		st.latched = lat;
		st.safe = safe;
		st.kick = kick;
		st.rec = rec;
		st.counts[CNT_SAFE] = n_safe;
		st.counts[CNT_ENC] = n_enc;
		st.counts[CNT_OC] = n_oc;
		st.counts[CNT_PWR] = n_pwr;
		st.counts[CNT_RECOV] = n_rec;
		st.counts[CNT_KICK] = n_kick;
		return st;
	endfunction

	function automatic stim_t row(logic [2:0] code, logic [31:0] now, logic enc,
			logic [15:0] cl, logic [15:0] cr, logic [15:0] mv);
		stim_t s;
		s.ev.req_type = code;
		s.ev.now_ms = now;
		s.ev.encoder_valid = enc;
		s.ev.current_left = cl;
		s.ev.current_right = cr;
		s.ev.supply_reading = mv;
		s.pinned = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic stim_t pin(stim_t s, status_t want);
		s.pinned = 1'b1;
		s.want = want;
		return s;
	endfunction

	function automatic void queue_event(stim_t s);
		events_to_send.push_back(s);
		status_owed++;
	endfunction

	// Every field random, including the unused request codes.
	function automatic item_t noise_item();
		item_t ev;
		ev.req_type = 3'($urandom_range(0, 7));
		ev.now_ms = $urandom();
		ev.encoder_valid = 1'($urandom_range(0, 1));
		ev.current_left = 16'($urandom_range(0, 65535));
		ev.current_right = 16'($urandom_range(0, 65535));
		ev.supply_reading = 16'($urandom_range(0, 65535));
		return ev;
	endfunction

	// A reading placed relative to a threshold, clamped to the field's range, with the
	// odd one drawn from the whole range.
	function automatic logic [15:0] level(logic [15:0] pivot, int lo, int hi);
		int v;
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom_range(0, 65535));
		v = int'(pivot) + lo + int'($urandom_range(0, hi - lo));
		if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Random traffic made mostly of bursts of one kind of event, so that debounce counts climb
	// to confirmation and the safe state is entered and left again. Time mostly moves
	// forward in small steps, with the occasional long gap or jump anywhere.
	task automatic add_random(int unsigned n_items);
		int unsigned made;
		int unsigned kind;
		int unsigned len;
		logic        hot_l;
		logic        hot_r;
		stim_t       s;
		made = 0;
		@(negedge clk);
		while (made < n_items) begin
			kind = $urandom_range(0, 99);
			len = (kind >= 88 && kind < 93) ? 1 : $urandom_range(1, 6);
			hot_l = 1'($urandom_range(0, 1));
			hot_r = 1'($urandom_range(0, 1));
			for (int k = 0; k < len; k++) begin
				s = row(REQ_TICK, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0);
				s.ev = noise_item();
				if ($urandom_range(0, 49) == 0)
					clock_ms = $urandom();
				else if ($urandom_range(0, 3) == 0)
					clock_ms += $urandom_range(0, 2000);
				else
					clock_ms += $urandom_range(0, 250);
				if (kind < 93)
					s.ev.now_ms = clock_ms;
				if (kind < 25) begin
					s.ev.req_type = REQ_ENCODER;
					s.ev.encoder_valid = (k == 0) ? 1'($urandom_range(0, 1))
						: ($urandom_range(0, 5) == 0);
				end else if (kind < 45) begin
					s.ev.req_type = REQ_CURRENT;
					s.ev.current_left = hot_l ? level(cfg_model.oc_limit, 1, 200)
						: level(cfg_model.oc_limit, -4, 4);
					s.ev.current_right = hot_r ? level(cfg_model.oc_limit, 1, 200)
						: level(cfg_model.oc_limit, -4, 4);
				end else if (kind < 60) begin
					s.ev.req_type = REQ_SUPPLY;
					s.ev.supply_reading = hot_l ? level(cfg_model.supply_low, -200, -1)
						: level(cfg_model.supply_low, -4, 4);
				end else if (kind < 88) begin
					s.ev.req_type = REQ_TICK;
				end else if (kind < 93) begin
					s.ev.req_type = REQ_CLEAR;
				end
				queue_event(s);
				made++;
			end
		end
	endtask

	// Returns once every expected result transaction has been received and checked.
	task automatic drain();
		@(posedge clk);
		while (status_owed != 0)
			@(posedge clk);
	endtask

	// APB write: a setup phase, then an access phase that completes when pready is high.
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_ENC_TIMEOUT: cfg_model.enc_timeout = value;
		REG_OC_LIMIT:    cfg_model.oc_limit = value[15:0];
		REG_SUPPLY_LOW:  cfg_model.supply_low = value[15:0];
		REG_RECOV_DELAY: cfg_model.recov_delay = value;
		default: ;
		endcase
	endtask

	task automatic load_config(cfg_t c);
		write_reg(REG_ENC_TIMEOUT, c.enc_timeout);
		write_reg(REG_OC_LIMIT, {16'd0, c.oc_limit});
		write_reg(REG_SUPPLY_LOW, {16'd0, c.supply_low});
		write_reg(REG_RECOV_DELAY, c.recov_delay);
	endtask

	// Request side. A transaction is taken at an edge where valid is high and stall low;
	// at that moment the predictor works out its status, and the state copy advances even
	// where the status is typed in. A stalled transaction is held unchanged, otherwise the
	// next one is offered unless the sender chooses to idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predicted = advance_monitor(held.ev);
				pending_status.push_back(held.pinned ? held.want : predicted);
			end
			if (!(req_valid && req_stall)) begin
				if (events_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					held = events_to_send.pop_front();
					req_valid <= 1'b1;
					req_type <= held.ev.req_type;
					now_ms <= held.ev.now_ms;
					encoder_valid <= held.ev.encoder_valid;
					current_left <= held.ev.current_left;
					current_right <= held.ev.current_right;
					supply_reading <= held.ev.supply_reading;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result side. Each accepted result transaction is checked field by field against
	// the oldest expected status. The stall is random, or held high for a long stretch
	// when a hold-off has been requested, which fills the block and backs up the requests.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_status.size() == 0) begin
				$display("%0t ns: result transaction arrived with no status expected", $time);
				errors++;
			end else begin
				want_st = pending_status.pop_front();
				status_owed--;
				seen_st.active = active_faults;
				seen_st.latched = latched_faults;
				seen_st.safe = safe_state;
				seen_st.kick = watchdog_kick;
				seen_st.rec = recovered;
				seen_st.counts[CNT_SAFE] = safe_entries;
				seen_st.counts[CNT_ENC] = encoder_timeout_events;
				seen_st.counts[CNT_OC] = overcurrent_count;
				seen_st.counts[CNT_PWR] = power_low_count;
				seen_st.counts[CNT_RECOV] = recovery_count;
				seen_st.counts[CNT_KICK] = kick_count;
				compare_field("active_faults", 32'(want_st.active), 32'(seen_st.active));
				compare_field("latched_faults", 32'(want_st.latched), 32'(seen_st.latched));
				compare_field("safe_state", 32'(want_st.safe), 32'(seen_st.safe));
				compare_field("watchdog_kick", 32'(want_st.kick), 32'(seen_st.kick));
				compare_field("recovered", 32'(want_st.rec), 32'(seen_st.rec));
				for (int i = 0; i < 6; i++)
					compare_field(count_names[i], want_st.counts[i], seen_st.counts[i]);
			end
		end
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
		rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("debounced_fault_safety_monitor_core test failed");
			$finish;
		end
	end

	initial begin
		stim_t directed[24];
		cfg_t  rnd;

		req_valid = 1'b0;
		req_type = 3'd0;
		now_ms = 32'd0;
		encoder_valid = 1'b0;
		current_left = 16'd0;
		current_right = 16'd0;
		supply_reading = 16'd0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;
		arst_n = 1'b0;

		cfg_model = '{RST_ENC_TIMEOUT, RST_OC_LIMIT, RST_SUPPLY_LOW, RST_RECOV_DELAY};
		fault_bits = 8'd0;
		latched_bits = 8'd0;
		safe_on = 1'b0;
		entry_ms = 32'd0;
		last_enc_ms = 32'd0;
		deb = '0;
		counts = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sequence under the reset configuration. It walks an encoder timeout
		// at the top of the time range into the safe state, a recovery after the delay
		// with the time wrapped, both motors running over the limit (exactly at the limit
		// counts as fine), a low supply confirmed repeatedly, a clear, the unused request
		// codes and extreme values in the fields that an event does not look at.
		directed = '{
			pin(row(REQ_TICK, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0),
				make_status(8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0, 0, 0, 0, 1)),
			row(REQ_ENCODER, 32'd100, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			row(REQ_ENCODER, 32'd700, 1'b0, 16'd0, 16'd0, 16'd0),
			pin(row(REQ_ENCODER, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0, 16'd0),
				make_status(F_STALE | F_INVALID, F_INVALID, 1'b1, 1'b0, 1'b0,
					1, 1, 0, 0, 0, 1)),
			row(REQ_TICK, 32'h100, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_ENCODER, 32'h200, 1'b1, 16'd0, 16'd0, 16'd0),
			row(REQ_TICK, 32'h300, 1'b0, 16'd0, 16'd0, 16'd0),
			pin(row(REQ_TICK, 32'd2000, 1'b0, 16'd0, 16'd0, 16'd0),
				make_status(8'd0, F_INVALID, 1'b0, 1'b0, 1'b1, 1, 1, 0, 0, 1, 1)),
			row(REQ_CURRENT, 32'd2100, 1'b0, 16'hFFFF, 16'd0, 16'd0),
			row(REQ_CURRENT, 32'd2200, 1'b0, 16'd3001, 16'd3001, 16'd0),
			row(REQ_CURRENT, 32'd2300, 1'b0, 16'd3001, 16'hFFFF, 16'd0),
			row(REQ_CURRENT, 32'd2400, 1'b0, 16'd3000, 16'hFFFF, 16'd0),
			row(REQ_CURRENT, 32'd2500, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_SUPPLY, 32'd2600, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_SUPPLY, 32'd2700, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_SUPPLY, 32'd2800, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_SUPPLY, 32'd2900, 1'b0, 16'd0, 16'd0, 16'd9999),
			row(REQ_SUPPLY, 32'd3000, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_SUPPLY, 32'd3100, 1'b0, 16'd0, 16'd0, 16'd10000),
			pin(row(REQ_CLEAR, 32'd3200, 1'b0, 16'd0, 16'd0, 16'd0),
				make_status(8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 2, 1, 2, 2, 1, 1)),
			row(REQ_SPARE_LO, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			row(REQ_SPARE_HI, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_TICK, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0, 16'd0),
			row(REQ_SUPPLY, 32'd0, 1'b0, 16'd0, 16'd0, 16'hFFFF)
		};
		@(negedge clk);
		foreach (directed[i])
			queue_event(directed[i]);
		drain();

		// Back-pressure: the receiver holds off for a long stretch while the sender keeps
		// offering transactions, so the block fills and has to stall its request side.
		@(negedge clk);
		hold_request = 1'b1;
		add_random(40);
		drain();

		// Random phases. Each runs under its own configuration, written while the block
		// is idle, and its own mix of idling on the two sides.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1) begin
				load_config('{32'd0, 16'd0, 16'hFFFF, 32'd0});
			end else if (p == 2) begin
				load_config('{32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF});
			end else if (p > 2) begin
				rnd.enc_timeout = ($urandom_range(0, 3) == 0) ? $urandom()
					: $urandom_range(1, 400);
				rnd.oc_limit = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(500, 60000));
				rnd.supply_low = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(500, 60000));
				rnd.recov_delay = ($urandom_range(0, 3) == 0) ? $urandom()
					: $urandom_range(0, 800);
				load_config(rnd);
			end
			@(negedge clk);
			idle_pct = SEND_IDLE_PCT[p % 4];
			stall_pct = RECV_STALL_PCT[p % 4];
			add_random(PHASE_ITEMS);
			drain();
		end

		// A quiet stretch so that any stray result transaction is still caught.
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("debounced_fault_safety_monitor_core test passed");
		else
			$display("debounced_fault_safety_monitor_core test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dfsm_pkg.sv
rtl/core/dfsm_cfg_regs.sv
rtl/core/dfsm_update.sv
rtl/core/debounced_fault_safety_monitor_core.sv
sim/tb.sv
